[src/jsu_pkg.sv]
`timescale 1ns / 1ps

package jsu_pkg;

	// Decoder phase, one-hot.
	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_BODY = 4'b0010,
		PH_ESC  = 4'b0100,
		PH_HEX  = 4'b1000
	} phase_t;

	// Kind of one result word.
	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_DONE = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	// All result words caused by one input word.
	typedef struct packed {
		kind_t           kind;
		logic [1:0]      count;
		logic [2:0][7:0] bytes;
	} group_t;

	// Hex digit decode result.
	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	// Characters of interest.
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	// Decoded control bytes of the simple escapes.
	localparam logic [7:0] BS_BYTE = 8'h08;
	localparam logic [7:0] FF_BYTE = 8'h0C;
	localparam logic [7:0] LF_BYTE = 8'h0A;
	localparam logic [7:0] CR_BYTE = 8'h0D;
	localparam logic [7:0] HT_BYTE = 8'h09;

	// Bytes that may not appear raw inside a string.
	localparam logic [7:0] CTRL_MAX = 8'h1F;
	localparam logic [7:0] DEL_BYTE = 8'h7F;

	// Decode one ASCII hex digit, either case.
	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h = '0;
		if (c inside {[8'h30:8'h39]}) begin
			h.valid = 1'b1;
			h.value = 4'(c - 8'h30);
		end else if (c inside {[8'h41:8'h46]}) begin
			h.valid = 1'b1;
			h.value = 4'(c - 8'h37);
		end else if (c inside {[8'h61:8'h66]}) begin
			h.valid = 1'b1;
			h.value = 4'(c - 8'h57);
		end
		return h;
	endfunction

endpackage

[src/jsu_ifs.sv]
`timescale 1ns / 1ps

// Input channel: one raw text byte per word.
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source (output valid, output in_byte, output end_of_input, input ready);
	modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

// Output channel: one decoded result per word.
interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output kind, output out_byte, output last, input ready);
	modport sink (input valid, input kind, input out_byte, input last, output ready);
endinterface

[src/json_string_unescaper_top.sv]
// A result group enters the registered result queue when the input word that causes it is taken.
// Throughput: one input word per cycle while the two-group result queue has room.
// A \u escape that ends in a two- or three-byte UTF-8 sequence holds the queue head for two
// or three output words; the queue takes one more result group meanwhile, then the input stalls
// until the long group is gone. Ready depends only on the queue fill count.
// Reset (arst_n low, asynchronous): idle, awaiting the opening quote, result queue empty.
`timescale 1ns / 1ps

module json_string_unescaper_top (
	input logic clk,
	input logic arst_n,
	jsu_in_if.sink    in_ch,
	jsu_out_if.source out_ch
);
	import jsu_pkg::*;

	localparam int unsigned QDEPTH = 2;

	// Decoder state.
	phase_t      phase_q, phase_d;
	logic [1:0]  left_q, left_d;
	logic [15:0] cp_q, cp_d;

	// Result group queue.
	group_t      grp_q [QDEPTH];
	group_t      grp_d;
	logic        push_d;
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic [1:0]  idx_q;

	logic        in_acc, out_acc, pop;
	group_t      head;
	hex_t        hv;
	logic [15:0] cp_new;

	assign in_acc = in_ch.valid && in_ch.ready;
	assign hv     = hex_value(in_ch.in_byte);
	assign cp_new = cp_q | ({12'b0, hv.value} << {left_q, 2'b00});

	// Decode one input byte into the next state and a result group.
	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		cp_d    = cp_q;
		push_d  = 1'b0;
		grp_d   = '0;
		grp_d.kind  = KIND_DATA;
		grp_d.count = 2'd1;
		if (in_ch.end_of_input) begin
			phase_d = PH_IDLE;
			left_d  = '0;
			cp_d    = '0;
			push_d  = 1'b1;
			grp_d.kind = KIND_ERR;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (in_ch.in_byte == CH_QUOTE) begin
						phase_d = PH_BODY;
					end else begin
						push_d     = 1'b1;
						grp_d.kind = KIND_ERR;
					end
				end
				PH_BODY: begin
					if (in_ch.in_byte == CH_QUOTE) begin
						phase_d    = PH_IDLE;
						push_d     = 1'b1;
						grp_d.kind = KIND_DONE;
					end else if (in_ch.in_byte == CH_BSLASH) begin
						phase_d = PH_ESC;
					end else if (in_ch.in_byte <= CTRL_MAX || in_ch.in_byte == DEL_BYTE) begin
						phase_d    = PH_IDLE;
						push_d     = 1'b1;
						grp_d.kind = KIND_ERR;
					end else begin
						push_d         = 1'b1;
						grp_d.bytes[0] = in_ch.in_byte;
					end
				end
				PH_ESC: begin
					phase_d = PH_BODY;
					push_d  = 1'b1;
					case (in_ch.in_byte)
						CH_QUOTE, CH_BSLASH, CH_SLASH: grp_d.bytes[0] = in_ch.in_byte;
						CH_B: grp_d.bytes[0] = BS_BYTE;
						CH_F: grp_d.bytes[0] = FF_BYTE;
						CH_N: grp_d.bytes[0] = LF_BYTE;
						CH_R: grp_d.bytes[0] = CR_BYTE;
						CH_T: grp_d.bytes[0] = HT_BYTE;
						CH_U: begin
							phase_d = PH_HEX;
							left_d  = 2'd3;
							cp_d    = '0;
							push_d  = 1'b0;
						end
						default: begin
							phase_d    = PH_IDLE;
							left_d     = '0;
							cp_d       = '0;
							grp_d.kind = KIND_ERR;
						end
					endcase
				end
				PH_HEX: begin
					if (!hv.valid) begin
						phase_d    = PH_IDLE;
						left_d     = '0;
						cp_d       = '0;
						push_d     = 1'b1;
						grp_d.kind = KIND_ERR;
					end else if (left_q != 2'd0) begin
						left_d = left_q - 2'd1;
						cp_d   = cp_new;
					end else begin
						// Last digit: emit the code point as UTF-8.
						phase_d = PH_BODY;
						cp_d    = '0;
						push_d  = 1'b1;
						if (cp_new[15:7] == '0) begin
							grp_d.bytes[0] = cp_new[7:0];
						end else if (cp_new[15:11] == '0) begin
							grp_d.count    = 2'd2;
							grp_d.bytes[0] = {3'b110, cp_new[10:6]};
							grp_d.bytes[1] = {2'b10, cp_new[5:0]};
						end else begin
							grp_d.count    = 2'd3;
							grp_d.bytes[0] = {4'b1110, cp_new[15:12]};
							grp_d.bytes[1] = {2'b10, cp_new[11:6]};
							grp_d.bytes[2] = {2'b10, cp_new[5:0]};
						end
					end
				end
				default: begin
					phase_d    = PH_IDLE;
					left_d     = '0;
					cp_d       = '0;
					push_d     = 1'b1;
					grp_d.kind = KIND_ERR;
				end
			endcase
		end
	end

	// Decoder state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			left_q  <= '0;
			cp_q    <= '0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			cp_q    <= cp_d;
		end
	end

	// Output side: read the head group one word at a time.
	assign head            = grp_q[rd_ptr_q];
	assign in_ch.ready     = cnt_q != 2'(QDEPTH);
	assign out_ch.valid    = cnt_q != 2'd0;
	assign out_ch.kind     = head.kind;
	assign out_ch.out_byte = (head.kind == KIND_DATA) ? head.bytes[idx_q] : 8'h00;
	assign out_ch.last     = idx_q == (head.count - 2'd1);
	assign out_acc         = out_ch.valid && out_ch.ready;
	assign pop             = out_acc && out_ch.last;

	// Queue payload.
	always_ff @(posedge clk) begin
		if (in_acc && push_d) begin
			grp_q[wr_ptr_q] <= grp_d;
		end
	end

	// Queue control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
			idx_q    <= '0;
		end else begin
			if (in_acc && push_d) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(in_acc && push_d) - 2'(pop);
			if (out_acc) begin
				idx_q <= out_ch.last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	// The queue never overflows.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(QDEPTH))
		else $error("result queue count out of range");

	// The word index stays inside the head group.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (idx_q < head.count && head.count != 2'd0))
		else $error("word index beyond head group");

	// The partial code point is clear outside the hex digits.
	a_cp_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_HEX |-> cp_q == '0)
		else $error("stale code point outside hex phase");

	// Only data words carry multi-word groups.
	a_multi_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && head.count != 2'd1) |-> head.kind == KIND_DATA)
		else $error("multi-word group with non-data kind");

endmodule
